[src/bfsp_pkg.sv]
`timescale 1ns / 1ps

package bfsp_pkg;

  localparam int MAX_VERTICES_DEF = 32;
  localparam int MAX_EDGES_DEF    = 256;

  localparam int VID_W    = 5;
  localparam int WEIGHT_W = 16;
  localparam int DIST_W   = 24;
  localparam int VCNT_W   = 6;
  localparam int EDGE_W   = 2 * VID_W + WEIGHT_W;

  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 40;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 6;

  localparam logic [CFG_IDX_W-1:0] REG_VERTEX_COUNT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_VERTEX = 2'd1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INIT,
    ST_EREAD,
    ST_VREAD,
    ST_RELAX,
    ST_OREAD,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic                       reach;
    logic [VID_W-1:0]           pred;
    logic signed [DIST_W-1:0]   dist_val;
  } vrec_t;

  typedef struct packed {
    logic signed [WEIGHT_W-1:0] weight;
    logic [VID_W-1:0]           to_v;
    logic [VID_W-1:0]           from_v;
  } edge_t;

endpackage

[src/bellman_ford_shortest_path.sv]
`timescale 1ns / 1ps
// Edge load: one edge per cycle, in_tready high whenever no run is active.
// Run (starts after the edge flagged tlast): vertex init over the n vertices, then
// (n + 1) passes over the stored edges, each edge taking an edge RAM read, a
// registered vertex RAM read and a relax step; the check pass stops at the first hit.
// Output: per result, a vertex RAM read, then a transfer that waits on out_tready.
// Reset (rst_n low, synchronous) resets control, edge count and config regs (vertex count to 1).
module bellman_ford_shortest_path #(
  parameter int MAX_VERTICES = bfsp_pkg::MAX_VERTICES_DEF,
  parameter int MAX_EDGES    = bfsp_pkg::MAX_EDGES_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [bfsp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [bfsp_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // from_vertex[4:0], to_vertex[9:5], weight[25:10], zero fill
  input  logic [bfsp_pkg::IN_DATA_W-1:0]    in_tdata,
  input  logic                              in_tlast,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // vertex[4:0], distance[28:5], predecessor[33:29], reachable[34], zero fill
  output logic [bfsp_pkg::OUT_DATA_W-1:0]   out_tdata,
  // negative_cycle[0]
  output logic                              out_tuser,
  output logic                              out_tlast
);

  localparam int VAW = $clog2(MAX_VERTICES);
  localparam int NW  = $clog2(MAX_VERTICES + 1);
  localparam int EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int CW  = $clog2(MAX_EDGES + 1);
  localparam int VID_W  = bfsp_pkg::VID_W;
  localparam int DIST_W = bfsp_pkg::DIST_W;

  bfsp_pkg::state_t state_r, state_nxt;

  logic [bfsp_pkg::VCNT_W-1:0] vc_r;
  logic [VID_W-1:0]            src_r;
  logic [CW-1:0]               edge_cnt_r, edge_cnt_nxt;
  logic [EAW-1:0]              e_r, e_nxt;
  logic [NW-1:0]               i_r, i_nxt;
  logic [NW-1:0]               pass_r, pass_nxt;
  logic [NW-1:0]               n_r, n_nxt;
  logic [VID_W-1:0]            s_r, s_nxt;
  logic                        check_r, check_nxt;
  logic                        neg_r, neg_nxt;

  // edge RAM
  bfsp_pkg::edge_t edge_mem [MAX_EDGES];
  bfsp_pkg::edge_t edge_rd_r;
  logic            edge_we;
  logic            edge_re;

  // vertex RAM: one write port, two registered read ports
  bfsp_pkg::vrec_t vmem [MAX_VERTICES];
  bfsp_pkg::vrec_t va_r, vb_r;
  logic            v_we, v_re;
  logic [VAW-1:0]  v_waddr, va_addr, vb_addr;
  bfsp_pkg::vrec_t v_wdata;

  logic in_xfer, out_xfer, cfg_xfer;
  logic edge_ok, relax_hit, edge_end, is_last_vertex;
  logic signed [DIST_W:0]   cand;
  logic signed [DIST_W-1:0] cand_sat;
  logic [NW-1:0]            n_start;

  assign cfg_ready = 1'b1;
  assign cfg_xfer  = cfg_valid & cfg_ready;
  assign in_xfer   = in_tvalid & in_tready;
  assign out_xfer  = out_tvalid & out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vc_r  <= bfsp_pkg::VCNT_W'(1);
      src_r <= '0;
    end else if (cfg_xfer) begin
      unique case (cfg_index)
        bfsp_pkg::REG_VERTEX_COUNT:  vc_r  <= cfg_data;
        bfsp_pkg::REG_SOURCE_VERTEX: src_r <= cfg_data[VID_W-1:0];
        default: ;
      endcase
    end
  end

  // saturate the configured count to 1..MAX_VERTICES
  always_comb begin
    priority if (vc_r == '0) begin
      n_start = NW'(1);
    end else if (8'(vc_r) > 8'(MAX_VERTICES)) begin
      n_start = NW'(MAX_VERTICES);
    end else begin
      n_start = NW'(vc_r);
    end
  end

  // relaxation datapath on the registered edge and vertex reads
  assign edge_ok = (8'(edge_rd_r.from_v) < 8'(n_r)) && (8'(edge_rd_r.to_v) < 8'(n_r))
                   && va_r.reach;
  assign cand    = (DIST_W+1)'(va_r.dist_val) + (DIST_W+1)'(edge_rd_r.weight);
  assign relax_hit = edge_ok && (!vb_r.reach || (cand < (DIST_W+1)'(vb_r.dist_val)));
  assign edge_end  = (CW'(e_r) + CW'(1)) == edge_cnt_r;
  assign is_last_vertex = (i_r + NW'(1)) == n_r;

  always_comb begin
    if (cand[DIST_W] != cand[DIST_W-1]) begin
      cand_sat = cand[DIST_W] ? {1'b1, {(DIST_W-1){1'b0}}} : {1'b0, {(DIST_W-1){1'b1}}};
    end else begin
      cand_sat = cand[DIST_W-1:0];
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      bfsp_pkg::ST_IDLE:  if (in_xfer && in_tlast) state_nxt = bfsp_pkg::ST_INIT;
      bfsp_pkg::ST_INIT:  if (is_last_vertex) state_nxt = bfsp_pkg::ST_EREAD;
      bfsp_pkg::ST_EREAD: state_nxt = bfsp_pkg::ST_VREAD;
      bfsp_pkg::ST_VREAD: state_nxt = bfsp_pkg::ST_RELAX;
      bfsp_pkg::ST_RELAX: begin
        priority if (check_r && relax_hit) begin
          state_nxt = bfsp_pkg::ST_OREAD;
        end else if (edge_end && check_r) begin
          state_nxt = bfsp_pkg::ST_OREAD;
        end else begin
          state_nxt = bfsp_pkg::ST_EREAD;
        end
      end
      bfsp_pkg::ST_OREAD: state_nxt = bfsp_pkg::ST_OUT;
      bfsp_pkg::ST_OUT: begin
        if (out_xfer) begin
          state_nxt = (neg_r || is_last_vertex) ? bfsp_pkg::ST_IDLE : bfsp_pkg::ST_OREAD;
        end
      end
      default: state_nxt = bfsp_pkg::ST_IDLE;
    endcase
  end

  // outputs, memory controls and counters
  always_comb begin
    in_tready    = 1'b0;
    out_tvalid   = 1'b0;
    edge_we      = 1'b0;
    edge_re      = 1'b0;
    v_we         = 1'b0;
    v_re         = 1'b0;
    v_waddr      = i_r[VAW-1:0];
    va_addr      = i_r[VAW-1:0];
    vb_addr      = i_r[VAW-1:0];
    v_wdata      = '0;
    edge_cnt_nxt = edge_cnt_r;
    e_nxt        = e_r;
    i_nxt        = i_r;
    pass_nxt     = pass_r;
    n_nxt        = n_r;
    s_nxt        = s_r;
    check_nxt    = check_r;
    neg_nxt      = neg_r;
    unique case (state_r)
      bfsp_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_xfer) begin
          if (edge_cnt_r < CW'(MAX_EDGES)) begin
            edge_we      = 1'b1;
            edge_cnt_nxt = edge_cnt_r + CW'(1);
          end
          if (in_tlast) begin
            n_nxt     = n_start;
            s_nxt     = src_r;
            i_nxt     = '0;
            pass_nxt  = '0;
            e_nxt     = '0;
            check_nxt = 1'b0;
            neg_nxt   = 1'b0;
          end
        end
      end
      bfsp_pkg::ST_INIT: begin
        v_we             = 1'b1;
        v_wdata.reach    = (8'(i_r) == 8'(s_r));
        v_wdata.pred     = s_r;
        v_wdata.dist_val = '0;
        i_nxt            = is_last_vertex ? '0 : i_r + NW'(1);
      end
      bfsp_pkg::ST_EREAD: edge_re = 1'b1;
      bfsp_pkg::ST_VREAD: begin
        v_re    = 1'b1;
        va_addr = VAW'(edge_rd_r.from_v);
        vb_addr = VAW'(edge_rd_r.to_v);
      end
      bfsp_pkg::ST_RELAX: begin
        v_waddr          = VAW'(edge_rd_r.to_v);
        v_wdata.reach    = 1'b1;
        v_wdata.pred     = edge_rd_r.from_v;
        v_wdata.dist_val = cand_sat;
        if (!check_r && relax_hit) v_we = 1'b1;
        priority if (check_r && relax_hit) begin
          neg_nxt      = 1'b1;
          i_nxt        = '0;
          edge_cnt_nxt = '0;
        end else if (edge_end) begin
          e_nxt = '0;
          if (check_r) begin
            i_nxt        = '0;
            edge_cnt_nxt = '0;
          end else if ((pass_r + NW'(1)) == n_r) begin
            check_nxt = 1'b1;
          end else begin
            pass_nxt = pass_r + NW'(1);
          end
        end else begin
          e_nxt = e_r + EAW'(1);
        end
      end
      bfsp_pkg::ST_OREAD: v_re = 1'b1;
      bfsp_pkg::ST_OUT: begin
        out_tvalid = 1'b1;
        if (out_xfer) i_nxt = i_r + NW'(1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= bfsp_pkg::ST_IDLE;
      edge_cnt_r <= '0;
      e_r        <= '0;
      i_r        <= '0;
      pass_r     <= '0;
      n_r        <= NW'(1);
      s_r        <= '0;
      check_r    <= 1'b0;
      neg_r      <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      edge_cnt_r <= edge_cnt_nxt;
      e_r        <= e_nxt;
      i_r        <= i_nxt;
      pass_r     <= pass_nxt;
      n_r        <= n_nxt;
      s_r        <= s_nxt;
      check_r    <= check_nxt;
      neg_r      <= neg_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (edge_we) begin
      edge_mem[edge_cnt_r[EAW-1:0]] <= bfsp_pkg::edge_t'(in_tdata[bfsp_pkg::EDGE_W-1:0]);
    end
    if (edge_re) begin
      edge_rd_r <= edge_mem[e_r];
    end
  end

  always_ff @(posedge clk) begin
    if (v_we) begin
      vmem[v_waddr] <= v_wdata;
    end
    if (v_re) begin
      va_r <= vmem[va_addr];
      vb_r <= vmem[vb_addr];
    end
  end

  // hold the result from the registered read until the transfer
  always_comb begin
    out_tdata = '0;
    out_tuser = neg_r;
    out_tlast = neg_r | is_last_vertex;
    if (!neg_r) begin
      out_tdata[VID_W-1:0]                       = VID_W'(i_r);
      out_tdata[VID_W+DIST_W-1:VID_W]            = va_r.reach ? va_r.dist_val : '0;
      out_tdata[2*VID_W+DIST_W-1:VID_W+DIST_W]   = va_r.pred;
      out_tdata[2*VID_W+DIST_W]                  = va_r.reach;
    end
  end

endmodule
